FILE: hdl/huffman_bit_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// huffman bit decoder assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_BIT_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define HBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// types, sizes and codes shared by the huffman bit decoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbd_pkg;

    // tree size and longest code
    localparam int MAX_NODES    = 512;
    localparam int MAX_CODE_LEN = 16;

    // fixed field widths
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;
    localparam int SYM_W  = 8;

    localparam int ADDR_W     = $clog2(MAX_NODES);
    localparam int USED_W     = $clog2(MAX_NODES + 1);
    localparam int DEPTH_W    = $clog2(MAX_CODE_LEN + 1);
    localparam int CODE_IDX_W = $clog2(CODE_W);
    localparam int LEN_LIMIT  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_DECODE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol_in;
        logic              bit_in;
    } t_request;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_out;
        logic [1:0]       status;
    } t_result;

    // one tree node: symbol flag, symbol, children (0 = none)
    typedef struct packed {
        logic                   has_sym;
        logic [SYM_W-1:0]       sym;
        logic [1:0][ADDR_W-1:0] kid;
    } t_node;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC_FETCH,
        S_DEC_CHECK,
        S_LD_PROBE,
        S_LD_PARENT,
        S_LD_NEW
    } t_state;

    typedef struct packed {
        logic accept;
        logic clear;
        logic dec_root;
        logic dec_read;
        logic dec_fetch;
        logic dec_check;
        logic ld_start;
        logic ld_probe;
        logic ld_parent;
        logic ld_new;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       len_ok;
        logic       at_root;
        logic       probe_cont;
        logic       full;
        logic       ins_leaf;
    } t_dp_status;

endpackage

FILE: hdl/hbd_ctrl.sv
// ----------------------------------------------------------------------------
// hbd_ctrl
// sequencer for decode steps, code loads and table clears
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  hbd_pkg::t_dp_status i_sts,
    output hbd_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);

    hbd_pkg::t_state r_state;
    hbd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hbd_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_sts.req_type)
                        hbd_pkg::REQ_LOAD: begin
                            if (i_sts.len_ok) begin
                                n_state = hbd_pkg::S_LD_PROBE;
                            end
                        end
                        hbd_pkg::REQ_DECODE: begin
                            n_state = i_sts.at_root ? hbd_pkg::S_DEC_CHECK
                                                    : hbd_pkg::S_DEC_FETCH;
                        end
                        default: n_state = hbd_pkg::S_IDLE;
                    endcase
                end
            end
            hbd_pkg::S_DEC_FETCH: n_state = hbd_pkg::S_DEC_CHECK;
            hbd_pkg::S_DEC_CHECK: n_state = hbd_pkg::S_IDLE;
            hbd_pkg::S_LD_PROBE: begin
                if (!i_sts.probe_cont) begin
                    n_state = i_sts.full ? hbd_pkg::S_IDLE : hbd_pkg::S_LD_PARENT;
                end
            end
            hbd_pkg::S_LD_PARENT: begin
                n_state = i_sts.ins_leaf ? hbd_pkg::S_IDLE : hbd_pkg::S_LD_NEW;
            end
            hbd_pkg::S_LD_NEW: begin
                if (i_sts.ins_leaf) begin
                    n_state = hbd_pkg::S_IDLE;
                end
            end
            default: n_state = hbd_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            hbd_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.req_type)
                        hbd_pkg::REQ_LOAD:   o_cmd.ld_start = i_sts.len_ok;
                        hbd_pkg::REQ_DECODE: begin
                            o_cmd.dec_root = i_sts.at_root;
                            o_cmd.dec_read = !i_sts.at_root;
                        end
                        hbd_pkg::REQ_CLEAR:  o_cmd.clear = 1'b1;
                        default:             o_cmd.clear = 1'b0;
                    endcase
                end
            end
            hbd_pkg::S_DEC_FETCH: o_cmd.dec_fetch = 1'b1;
            hbd_pkg::S_DEC_CHECK: o_cmd.dec_check = 1'b1;
            hbd_pkg::S_LD_PROBE:  o_cmd.ld_probe  = 1'b1;
            hbd_pkg::S_LD_PARENT: o_cmd.ld_parent = 1'b1;
            hbd_pkg::S_LD_NEW:    o_cmd.ld_new    = 1'b1;
            default:              o_busy          = 1'b1;
        endcase
    end

endmodule

FILE: hdl/hbd_datapath.sv
// ----------------------------------------------------------------------------
// hbd_datapath
// node store, root shadow, walk registers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbd_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hbd_pkg::t_dp_cmd     i_cmd,
    input  hbd_pkg::t_request    i_req,
    output hbd_pkg::t_dp_status  o_sts,
    output logic                 o_valid,
    output hbd_pkg::t_result     o_result
);

    localparam int ADDR_W  = hbd_pkg::ADDR_W;
    localparam int USED_W  = hbd_pkg::USED_W;
    localparam int DEPTH_W = hbd_pkg::DEPTH_W;
    localparam int LEN_W   = hbd_pkg::LEN_W;

    // node store, entries at or above the fill count are never reached
    hbd_pkg::t_node r_mem [hbd_pkg::MAX_NODES];
    hbd_pkg::t_node r_rd_data;

    // control state
    hbd_pkg::t_node      r_root, n_root;
    logic [USED_W-1:0]   r_used, n_used;
    logic [ADDR_W-1:0]   r_walk_node, n_walk_node;
    logic [DEPTH_W-1:0]  r_walk_depth, n_walk_depth;
    logic                r_o_valid, n_o_valid;

    // payload and work registers
    logic [hbd_pkg::CODE_W-1:0] r_value;
    logic [LEN_W-1:0]           r_len;
    logic [hbd_pkg::SYM_W-1:0]  r_sym;
    logic                       r_bit;
    hbd_pkg::t_node             r_cur, n_cur;
    logic [ADDR_W-1:0]          r_cur_idx, n_cur_idx;
    logic [LEN_W-1:0]           r_i, n_i;
    logic [ADDR_W-1:0]          r_nxt, n_nxt;
    hbd_pkg::t_result           r_o_result, n_o_result;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;
    hbd_pkg::t_node        mem_wdata;

    hbd_pkg::t_node              view;
    hbd_pkg::t_node              wnode;
    logic [LEN_W-1:0]            code_pos;
    logic                        code_b;
    logic [ADDR_W-1:0]           probe_nxt;
    logic [ADDR_W-1:0]           root_nxt;
    logic [ADDR_W-1:0]           fetch_nxt;
    logic [LEN_W-1:0]            need;
    logic                        full;
    logic                        probe_cont;
    logic                        ins_leaf;
    logic                        len_ok;
    logic                        hit;
    logic [DEPTH_W-1:0]          depth_inc;

    // node under the load pointer: root from its shadow, others from the store
    assign view      = (r_cur_idx == '0) ? r_root : r_rd_data;
    assign code_pos  = r_len - LEN_W'(1) - r_i;
    assign code_b    = r_value[code_pos[hbd_pkg::CODE_IDX_W-1:0]];
    assign probe_nxt = view.kid[code_b];
    assign root_nxt  = r_root.kid[i_req.bit_in];
    assign fetch_nxt = r_rd_data.kid[r_bit];
    assign need      = r_len - r_i;
    assign full      = ({1'b0, r_used} + (USED_W + 1)'(need))
                       > (USED_W + 1)'(hbd_pkg::MAX_NODES);
    assign probe_cont = (r_i < r_len) && (probe_nxt != '0);
    assign ins_leaf  = (r_i == r_len);
    assign len_ok    = (i_req.code_length != '0)
                       && (i_req.code_length <= LEN_W'(hbd_pkg::LEN_LIMIT));
    assign hit       = (r_nxt != '0) && r_rd_data.has_sym;
    assign depth_inc = r_walk_depth + DEPTH_W'(1);

    always_comb begin
        n_root       = r_root;
        n_used       = r_used;
        n_walk_node  = r_walk_node;
        n_walk_depth = r_walk_depth;
        n_o_valid    = 1'b0;
        n_o_result   = r_o_result;
        n_cur        = r_cur;
        n_cur_idx    = r_cur_idx;
        n_i          = r_i;
        n_nxt        = r_nxt;
        mem_we       = 1'b0;
        mem_waddr    = r_cur_idx;
        mem_wdata    = r_cur;
        mem_raddr    = probe_nxt;
        wnode        = r_cur;

        if (i_cmd.clear) begin
            n_root       = '0;
            n_used       = USED_W'(1);
            n_walk_node  = '0;
            n_walk_depth = '0;
        end

        // walk at the root: child comes from the shadow, dead walk has none
        if (i_cmd.dec_root) begin
            n_nxt     = (r_walk_depth == '0) ? root_nxt : '0;
            mem_raddr = root_nxt;
        end
        if (i_cmd.dec_read) begin
            mem_raddr = r_walk_node;
        end
        if (i_cmd.dec_fetch) begin
            n_nxt     = fetch_nxt;
            mem_raddr = fetch_nxt;
        end
        if (i_cmd.dec_check) begin
            if (hit) begin
                n_o_valid    = 1'b1;
                n_o_result   = '{symbol_out: r_rd_data.sym, status: hbd_pkg::ST_OK};
                n_walk_node  = '0;
                n_walk_depth = '0;
            end else if (depth_inc >= DEPTH_W'(hbd_pkg::MAX_CODE_LEN)) begin
                n_o_valid    = 1'b1;
                n_o_result   = '{symbol_out: '0, status: hbd_pkg::ST_NOMATCH};
                n_walk_node  = '0;
                n_walk_depth = '0;
            end else begin
                n_walk_node  = r_nxt;
                n_walk_depth = depth_inc;
            end
        end

        if (i_cmd.ld_start) begin
            n_cur_idx = '0;
            n_i       = '0;
        end
        // follow the existing path one level a cycle
        if (i_cmd.ld_probe) begin
            if (probe_cont) begin
                n_cur_idx = probe_nxt;
                n_i       = r_i + LEN_W'(1);
            end else begin
                n_cur = view;
                if (full) begin
                    n_o_valid  = 1'b1;
                    n_o_result = '{symbol_out: '0, status: hbd_pkg::ST_FULL};
                end
            end
        end
        // last existing node: mark the symbol or hang the first new node
        if (i_cmd.ld_parent) begin
            wnode = r_cur;
            if (ins_leaf) begin
                wnode.has_sym = 1'b1;
                wnode.sym     = r_sym;
            end else begin
                wnode.kid[code_b] = r_used[ADDR_W-1:0];
                n_i               = r_i + LEN_W'(1);
            end
            if (r_cur_idx == '0) begin
                n_root = wnode;
            end else begin
                mem_we    = 1'b1;
                mem_waddr = r_cur_idx;
                mem_wdata = wnode;
            end
        end
        // fresh node, linked to the next one unless it ends the code
        if (i_cmd.ld_new) begin
            wnode = '0;
            if (ins_leaf) begin
                wnode.has_sym = 1'b1;
                wnode.sym     = r_sym;
            end else begin
                wnode.kid[code_b] = ADDR_W'(r_used + USED_W'(1));
                n_i               = r_i + LEN_W'(1);
            end
            mem_we    = 1'b1;
            mem_waddr = r_used[ADDR_W-1:0];
            mem_wdata = wnode;
            n_used    = r_used + USED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= '0;
            r_used       <= USED_W'(1);
            r_walk_node  <= '0;
            r_walk_depth <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_root       <= n_root;
            r_used       <= n_used;
            r_walk_node  <= n_walk_node;
            r_walk_depth <= n_walk_depth;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_req.code_value;
            r_len   <= i_req.code_length;
            r_sym   <= i_req.symbol_in;
            r_bit   <= i_req.bit_in;
        end
        r_cur      <= n_cur;
        r_cur_idx  <= n_cur_idx;
        r_i        <= n_i;
        r_nxt      <= n_nxt;
        r_o_result <= n_o_result;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    assign o_sts.req_type   = i_req.req_type;
    assign o_sts.len_ok     = len_ok;
    assign o_sts.at_root    = (r_walk_node == '0);
    assign o_sts.probe_cont = probe_cont;
    assign o_sts.full       = full;
    assign o_sts.ins_leaf   = ins_leaf;

    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

endmodule

FILE: hdl/huffman_bit_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_bit_decoder_unit
// prefix-code decoder on a binary code tree with loadable codes
// ----------------------------------------------------------------------------
//
//  channel   ports                      beat taken when
//  -------   -------------------------  -------------------------------
//  request   start, busy, i_req         start high and busy low
//  result    o_valid, o_result          o_valid high, one cycle, no stall
//
//  decode: a bit steps idle, fetch, check, skipping fetch while at the root;
//    a non-root node costs one extra node-store read before its child read
//  load: one probe read per existing level of the code's path, then an update
//    of the last existing node and one node-store write per new node; a
//    refused load ends after the probes; clear and ignored requests take 1 cycle
//  reset: ready right after reset, the node store needs no clearing pass
//    since the fill count hides stale entries and the root lives in flops
//  results cannot be stalled; each one is a single-cycle o_valid pulse
//
`timescale 1ns / 1ps
`include "huffman_bit_decoder_unit_macros.svh"

module huffman_bit_decoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  hbd_pkg::t_request i_req,
    output logic              o_valid,
    output hbd_pkg::t_result  o_result
);

    // command and status between sequencer and datapath
    hbd_pkg::t_dp_cmd    cmd;
    hbd_pkg::t_dp_status sts;

    // sequencer: picks the step, holds busy while an item is in flight
    hbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: node store, tree walk, insertion, result register
    hbd_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // a result only lands as the sequencer returns to idle
    `HBD_ASSERT_SAME(a_result_when_idle, o_valid, !busy, "result beat while busy")

    // error results carry a zero symbol
    `HBD_ASSERT_SAME(a_error_symbol_zero, o_valid && (o_result.status != hbd_pkg::ST_OK), o_result.symbol_out == '0, "error result with nonzero symbol")

    // clear leaves the sequencer idle and never reports
    `HBD_ASSERT_NEXT(a_clear_one_cycle, start && !busy && (i_req.req_type == hbd_pkg::REQ_CLEAR), !busy && !o_valid, "clear did not finish quietly")

    // a decode bit always needs at least one node-store read
    `HBD_ASSERT_NEXT(a_decode_holds_busy, start && !busy && (i_req.req_type == hbd_pkg::REQ_DECODE), busy && !o_valid, "decode finished without a read")

endmodule

FILE: dv/huffman_bit_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_decoder_unit_test
// self-checking bench for the prefix-code decoder: a short table of directed
// beats, then random code tables loaded and decoded bit by bit, with every
// result compared against a behavioral copy of the code tree
// ----------------------------------------------------------------------------
module huffman_bit_decoder_unit_test;
    import hbd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 3;
    // cycles with no beat on either side before the run is declared hung
    localparam int QUIET_LIMIT  = 2000;
    // idle time after the last result, long enough to cover any trailing load work
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1100;
    // request code the block must drop
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_req;
    logic     o_valid;
    t_result  o_result;

    huffman_bit_decoder_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // code tree model
    // ------------------------------------------------------------------------
    t_node       tree_nodes [MAX_NODES];
    int unsigned tree_used;
    int unsigned walk_at;      // 0 during a walk means the path left the tree
    int unsigned walk_bits;
    int unsigned full_refusals;

    t_result due_results [$];
    int      fail_count;
    bit      burst_mode;

    function automatic void tree_clear();
        for (int n = 0; n < MAX_NODES; n++) begin
            tree_nodes[n] = '0;
        end
        tree_used = 1;
        walk_at   = 0;
        walk_bits = 0;
    endfunction

    // returns 1 when the code needs more new nodes than are left
    function automatic bit tree_load(input logic [CODE_W-1:0] value,
                                     input int unsigned len,
                                     input logic [SYM_W-1:0] sym);
        int unsigned cur;
        int unsigned i;
        int unsigned nxt;
        int unsigned b;
        if (len == 0 || len > CODE_W || len > MAX_CODE_LEN) begin
            return 1'b0;
        end
        // count the levels already present along the path
        cur = 0;
        i   = 0;
        while (i < len) begin
            b   = 32'(value[len - 1 - i]);
            nxt = 32'(tree_nodes[cur].kid[b]);
            if (nxt == 0) begin
                break;
            end
            cur = nxt;
            i++;
        end
        if (tree_used > MAX_NODES || (len - i) > MAX_NODES - tree_used) begin
            return 1'b1;
        end
        cur = 0;
        for (i = 0; i < len; i++) begin
            b   = 32'(value[len - 1 - i]);
            nxt = 32'(tree_nodes[cur].kid[b]);
            if (nxt == 0) begin
                nxt = tree_used;
                tree_used++;
                tree_nodes[nxt] = '0;
                tree_nodes[cur].kid[b] = ADDR_W'(nxt);
            end
            cur = nxt;
        end
        tree_nodes[cur].has_sym = 1'b1;
        tree_nodes[cur].sym     = sym;
        return 1'b0;
    endfunction

    function automatic t_result result_of(input logic [SYM_W-1:0] sym, input logic [1:0] st);
        t_result res;
        res.symbol_out = sym;
        res.status     = st;
        return res;
    endfunction

    function automatic void predict_request(input t_request rq, output bit got,
                                            output t_result res);
        int unsigned nxt;
        got = 1'b0;
        res = '0;
        case (rq.req_type)
            REQ_LOAD: begin
                if (tree_load(rq.code_value, 32'(rq.code_length), rq.symbol_in)) begin
                    full_refusals++;
                    got = 1'b1;
                    res = result_of('0, ST_FULL);
                end
            end
            REQ_DECODE: begin
                nxt = 0;
                if (walk_bits == 0 || walk_at != 0) begin
                    nxt = 32'(tree_nodes[walk_at].kid[rq.bit_in]);
                end
                walk_at = nxt;
                walk_bits++;
                if (nxt != 0 && tree_nodes[nxt].has_sym) begin
                    got       = 1'b1;
                    res       = result_of(tree_nodes[nxt].sym, ST_OK);
                    walk_at   = 0;
                    walk_bits = 0;
                end else if (walk_bits >= MAX_CODE_LEN) begin
                    got       = 1'b1;
                    res       = result_of('0, ST_NOMATCH);
                    walk_at   = 0;
                    walk_bits = 0;
                end
            end
            REQ_CLEAR: begin
                tree_clear();
            end
            default: begin
                // unknown request, dropped
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result check and hang watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got symbol %02h status %0d",
                         $time, o_result.symbol_out, o_result.status);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (o_result.symbol_out !== want.symbol_out) begin
                    $display("%0t: symbol_out mismatch, expected %02h, got %02h",
                             $time, want.symbol_out, o_result.symbol_out);
                    fail_count++;
                end
                if (o_result.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_result.status);
                    fail_count++;
                end
            end
        end
    end

    int unsigned quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned roll;
        if (burst_mode) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // random content in every field, request code forced
    function automatic t_request junk_req(input logic [1:0] kind);
        t_request rq;
        rq          = t_request'($urandom);
        rq.req_type = kind;
        return rq;
    endfunction

    function automatic t_request make_req(input logic [1:0] kind,
                                          input logic [CODE_W-1:0] value,
                                          input logic [LEN_W-1:0] len,
                                          input logic [SYM_W-1:0] sym,
                                          input logic b);
        t_request rq;
        rq.req_type    = kind;
        rq.code_value  = value;
        rq.code_length = len;
        rq.symbol_in   = sym;
        rq.bit_in      = b;
        return rq;
    endfunction

    // one beat after gap_cycles idle cycles; a typed expectation replaces
    // the predicted one while the model still tracks the state
    task automatic send_request(input t_request rq, input int gap_cycles, input bit typed,
                                input bit typed_has, input t_result typed_res);
        bit      got;
        t_result res;
        if (gap_cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= t_request'($urandom);
            repeat (gap_cycles - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        predict_request(rq, got, res);
        if (typed) begin
            got = typed_has;
            res = typed_res;
        end
        if (got) begin
            due_results.push_back(res);
        end
    endtask

    // hold requests off until every outstanding result has arrived
    task automatic drain_pause();
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= t_request'($urandom);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    typedef struct {
        t_request req;
        int       reps;
        bit       typed;    // expectation written in the row
        bit       has_res;  // typed rows: result on the last repeat
        t_result  res;
    } t_dir_row;

    t_dir_row dir_rows [$];

    task automatic add_row(input t_request rq, input int reps, input bit typed,
                           input bit has_res, input t_result res);
        t_dir_row row;
        row.req     = rq;
        row.reps    = reps;
        row.typed   = typed;
        row.has_res = has_res;
        row.res     = res;
        dir_rows.push_back(row);
    endtask

    initial begin
        logic [CODE_W-1:0] cw_val [$];
        int unsigned       cw_len [$];
        logic [SYM_W-1:0]  cw_sym [$];
        logic [CODE_W-1:0] v;
        t_request          rq;
        int unsigned       counted;
        int unsigned       n_target;
        int unsigned       max_len;
        int unsigned       k;
        int unsigned       first;
        int unsigned       n_words;
        int unsigned       w;
        bit                deep;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req         = '0;
        fail_count    = 0;
        full_refusals = 0;
        burst_mode    = 1'b0;
        tree_clear();

        // lengths outside 1..16 and an unknown request are dropped silently
        add_row(make_req(REQ_LOAD, 16'hFFFF, 5'd0, 8'hFF, 1'b1), 1, 1, 0, '0);
        add_row(make_req(REQ_LOAD, 16'hFFFF, 5'd17, 8'hFF, 1'b1), 1, 1, 0, '0);
        add_row(make_req(REQ_LOAD, 16'h0000, 5'd31, 8'h00, 1'b0), 1, 1, 0, '0);
        add_row(make_req(REQ_UNKNOWN, 16'hFFFF, 5'd31, 8'hFF, 1'b1), 1, 1, 0, '0);
        // 1 -> a5, 00 -> 00, 01 -> 3c then rewritten to ff; junk above the code bits
        add_row(make_req(REQ_LOAD, 16'hFFFF, 5'd1, 8'hA5, 1'b0), 1, 0, 0, '0);
        add_row(make_req(REQ_LOAD, 16'hFFFC, 5'd2, 8'h00, 1'b1), 1, 0, 0, '0);
        add_row(make_req(REQ_LOAD, 16'h5551, 5'd2, 8'h3C, 1'b0), 1, 0, 0, '0);
        add_row(make_req(REQ_LOAD, 16'h0001, 5'd2, 8'hFF, 1'b0), 1, 0, 0, '0);
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b1), 1, 1, 1,
                result_of(8'hA5, ST_OK));
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b0), 1, 0, 0, '0);
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b1), 1, 1, 1,
                result_of(8'hFF, ST_OK));
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b0), 1, 0, 0, '0);
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b0), 1, 1, 1,
                result_of(8'h00, ST_OK));
        // longest codes running through nodes that already hold a symbol
        add_row(make_req(REQ_LOAD, 16'hFFFF, 5'd16, 8'h81, 1'b0), 1, 0, 0, '0);
        add_row(make_req(REQ_DECODE, 16'hFFFF, 5'd31, 8'hFF, 1'b1), 1, 0, 0, '0);
        add_row(make_req(REQ_LOAD, 16'h0000, 5'd16, 8'h7E, 1'b1), 1, 0, 0, '0);
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b0), 2, 0, 0, '0);
        // leave a walk half done, the clear has to restart it
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b0), 1, 0, 0, '0);
        add_row(make_req(REQ_CLEAR, 16'hFFFF, 5'd31, 8'hFF, 1'b1), 1, 1, 0, '0);
        // a 16 bit code matches on the last allowed bit
        add_row(make_req(REQ_LOAD, 16'hFFFF, 5'd16, 8'hC3, 1'b1), 1, 0, 0, '0);
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b1), 16, 1, 1,
                result_of(8'hC3, ST_OK));
        // path falls off the tree at once and runs dead to the length limit
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b0), 1, 1, 0, '0);
        add_row(make_req(REQ_DECODE, 16'h0000, 5'd0, 8'h00, 1'b1), 15, 1, 1,
                result_of(8'h00, ST_NOMATCH));
        add_row(make_req(REQ_CLEAR, 16'h0000, 5'd0, 8'h00, 1'b0), 1, 1, 0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            for (int j = 0; j < dir_rows[r].reps; j++) begin
                send_request(dir_rows[r].req, pick_gap(), dir_rows[r].typed,
                             dir_rows[r].has_res && (j == dir_rows[r].reps - 1),
                             dir_rows[r].res);
            end
        end

        // fill the node store with long random codes until loads get refused
        counted = 0;
        send_request(junk_req(REQ_CLEAR), pick_gap(), 0, 0, '0);
        counted++;
        for (k = 0; k < 200 && full_refusals < 6; k++) begin
            rq             = junk_req(REQ_LOAD);
            rq.code_length = LEN_W'($urandom_range(10, 16));
            send_request(rq, pick_gap(), 0, 0, '0);
            counted++;
        end
        for (k = 0; k < 40; k++) begin
            send_request(junk_req(REQ_DECODE), pick_gap(), 0, 0, '0);
            counted++;
        end
        drain_pause();

        // rounds: build a random prefix code, load it, decode a message with it
        while (counted < RANDOM_ITEMS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            deep       = ($urandom_range(0, 4) == 0);
            max_len    = deep ? MAX_CODE_LEN : $urandom_range(3, 8);
            n_target   = deep ? $urandom_range(8, 17) : $urandom_range(2, 12);
            if (n_target > (1 << max_len)) begin
                n_target = 1 << max_len;
            end
            // now and then stack the new code onto the old tree
            if ($urandom_range(0, 9) < 7) begin
                send_request(junk_req(REQ_CLEAR), pick_gap(), 0, 0, '0);
                counted++;
            end

            // split leaves of a growing tree until there are enough codewords
            cw_val.delete();
            cw_len.delete();
            cw_sym.delete();
            cw_val.push_back('0);
            cw_len.push_back(0);
            while (cw_val.size() < n_target) begin
                k = (deep && $urandom_range(0, 1)) ? cw_val.size() - 1
                                                   : $urandom_range(0, cw_val.size() - 1);
                if (cw_len[k] < max_len) begin
                    v         = cw_val[k];
                    cw_val[k] = {v[CODE_W-2:0], 1'b0};
                    cw_len[k] = cw_len[k] + 1;
                    cw_val.push_back({v[CODE_W-2:0], 1'b1});
                    cw_len.push_back(cw_len[k]);
                end
            end
            foreach (cw_val[c]) begin
                cw_sym.push_back(SYM_W'($urandom));
            end

            first = $urandom_range(0, cw_val.size() - 1);
            for (w = 0; w < cw_val.size(); w++) begin
                k              = (first + w) % cw_val.size();
                rq             = junk_req(REQ_LOAD);
                rq.code_length = LEN_W'(cw_len[k]);
                rq.code_value  = (rq.code_value << cw_len[k]) | cw_val[k];
                rq.symbol_in   = cw_sym[k];
                send_request(rq, pick_gap(), 0, 0, '0);
                counted++;
                // dropped requests mixed in, not counted
                if ($urandom_range(0, 19) == 0) begin
                    if ($urandom_range(0, 1)) begin
                        rq = junk_req(REQ_UNKNOWN);
                    end else begin
                        rq             = junk_req(REQ_LOAD);
                        rq.code_length = LEN_W'($urandom_range(0, 1) ? 0
                                                                     : $urandom_range(17, 31));
                    end
                    send_request(rq, pick_gap(), 0, 0, '0);
                end
            end
            // rewrite the symbol of one codeword
            if ($urandom_range(0, 4) == 0) begin
                k              = $urandom_range(0, cw_val.size() - 1);
                cw_sym[k]      = SYM_W'($urandom);
                rq             = junk_req(REQ_LOAD);
                rq.code_length = LEN_W'(cw_len[k]);
                rq.code_value  = (rq.code_value << cw_len[k]) | cw_val[k];
                rq.symbol_in   = cw_sym[k];
                send_request(rq, pick_gap(), 0, 0, '0);
                counted++;
            end

            n_words = $urandom_range(5, 25);
            for (w = 0; w < n_words && counted < RANDOM_ITEMS; w++) begin
                k = $urandom_range(0, cw_val.size() - 1);
                for (int j = cw_len[k]; j > 0; j--) begin
                    rq        = junk_req(REQ_DECODE);
                    rq.bit_in = cw_val[k][j-1];
                    send_request(rq, pick_gap(), 0, 0, '0);
                    counted++;
                end
                // a stray bit throws the walk out of step with the message
                if ($urandom_range(0, 19) == 0) begin
                    send_request(junk_req(REQ_DECODE), pick_gap(), 0, 0, '0);
                    counted++;
                end
                if ($urandom_range(0, 99) == 0) begin
                    send_request(junk_req(REQ_CLEAR), pick_gap(), 0, 0, '0);
                    counted++;
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                drain_pause();
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
